[rtl/core/cksf_pkg.sv]
`timescale 1ns / 1ps

package cksf_pkg;

  // Fixed port widths
  localparam int SAMPLE_W   = 16;
  localparam int FW_W       = 13;
  localparam int FH_W       = 16;
  localparam int COEF_W     = 16;
  localparam int COEF_FRAC  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register reset values
  localparam logic [FW_W-1:0]   FW_RST = 13'd1920;
  localparam logic [FH_W-1:0]   FH_RST = 16'd1080;
  localparam logic [COEF_W-1:0] CC_RST = 16'd4096;
  localparam logic [COEF_W-1:0] CH_RST = 16'd0;
  localparam logic [COEF_W-1:0] CV_RST = 16'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH     = 3'd0,
    CFG_FRAME_HEIGHT    = 3'd1,
    CFG_COEF_CENTER     = 3'd2,
    CFG_COEF_HORIZONTAL = 3'd3,
    CFG_COEF_VERTICAL   = 3'd4,
    CFG_SHARPEN_ENABLE  = 3'd5,
    CFG_LUMA_ONLY       = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] chan_a;
    logic [SAMPLE_W-1:0] chan_b;
    logic [SAMPLE_W-1:0] chan_c;
    logic                flush;
  } pix_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] out_a;
    logic [SAMPLE_W-1:0] out_b;
    logic [SAMPLE_W-1:0] out_c;
    logic                end_of_frame;
  } pix_out_t;

  typedef struct packed {
    logic [COEF_W-1:0] center;
    logic [COEF_W-1:0] horizontal;
    logic [COEF_W-1:0] vertical;
  } coef_t;

endpackage

[rtl/core/cksf_stream_if.sv]
`timescale 1ns / 1ps

interface cksf_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/cksf_chan.sv]
`timescale 1ns / 1ps

// One channel of the cross kernel: products registered, then sum and clamp.
module cksf_chan import cksf_pkg::*; #(
  parameter int SB = 16
) (
  input  logic          clk_i,
  input  logic          filt_i,
  input  coef_t         coef_i,
  input  logic [SB-1:0] mid_i,
  input  logic [SB-1:0] up_i,
  input  logic [SB-1:0] dn_i,
  input  logic [SB-1:0] lf_i,
  input  logic [SB-1:0] rt_i,
  output logic [SB-1:0] res_o
);

  localparam int PW = SB + COEF_W;
  localparam int TW = PW - COEF_FRAC;
  localparam int SW = SB + 6;
  localparam logic [SB-1:0] SMAX = '1;

  logic [PW-1:0] pc_q, pu_q, pd_q, pl_q, pr_q;
  logic [SB-1:0] mid_q;
  logic          filt_q;
  logic [TW-1:0] tc;
  logic [SW-1:0] sum;
  logic [SB-1:0] clamp;

  function automatic logic [SB-1:0] side_sat(input logic [PW-1:0] p);
    if (|p[PW-1:SB+COEF_FRAC]) begin
      return SMAX;
    end
    return p[SB+COEF_FRAC-1:COEF_FRAC];
  endfunction

  always_ff @(posedge clk_i) begin
    pc_q   <= PW'(mid_i) * PW'(coef_i.center);
    pu_q   <= PW'(up_i) * PW'(coef_i.vertical);
    pd_q   <= PW'(dn_i) * PW'(coef_i.vertical);
    pl_q   <= PW'(lf_i) * PW'(coef_i.horizontal);
    pr_q   <= PW'(rt_i) * PW'(coef_i.horizontal);
    mid_q  <= mid_i;
    filt_q <= filt_i;
  end

  always_comb begin
    tc  = pc_q[PW-1:COEF_FRAC];
    sum = SW'(tc) - SW'(side_sat(pu_q)) - SW'(side_sat(pd_q))
        - SW'(side_sat(pl_q)) - SW'(side_sat(pr_q));
    if (sum[SW-1]) begin
      clamp = '0;
    end else if (|sum[SW-2:SB]) begin
      clamp = SMAX;
    end else begin
      clamp = sum[SB-1:0];
    end
    res_o = filt_q ? clamp : mid_q;
  end

endmodule

[rtl/core/cross_kernel_sharpen_filter.sv]
`timescale 1ns / 1ps

// Channel  | Dir | Handshake       | Payload
// ---------+-----+-----------------+---------------------------------------
// pix_i    | in  | valid / ready   | chan_a, chan_b, chan_c, flush
// pix_o    | out | valid / ready   | out_a, out_b, out_c, end_of_frame
// cfg      | in  | cfg_we_i        | cfg_idx_i, cfg_data_i (write only)
//
// One item per clock sustained while pix_o is not stalled. A result item passes
// through the line buffer read registers, the product registers and the
// sum/clamp into the output FIFO before it becomes valid on pix_o.
// Reset clears counters, configuration and the FIFO; the line buffers are
// not cleared (no clearing pass), every entry is written before it is read.
// A 4-entry output FIFO absorbs stalls on pix_o; pix_i.ready drops only while
// four results are in flight or waiting.
module cross_kernel_sharpen_filter import cksf_pkg::*; #(
  parameter int MAX_WIDTH   = 4096,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  cksf_stream_if.sink           pix_i,
  cksf_stream_if.source         pix_o
);

  localparam int SB         = SAMPLE_BITS;
  localparam int LW         = 3 * SB;
  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int WW         = $clog2(MAX_WIDTH + 1);
  localparam int EW         = (WW > FW_W) ? WW : FW_W;
  localparam int FIFO_DEPTH = 4;
  localparam int FPW        = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [FW_W-1:0]   fw_q;
  logic [FH_W-1:0]   fh_q;
  logic [COEF_W-1:0] cc_q, ch_q, cv_q;
  logic              en_q, luma_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= FW_RST;
      fh_q   <= FH_RST;
      cc_q   <= CC_RST;
      ch_q   <= CH_RST;
      cv_q   <= CV_RST;
      en_q   <= 1'b0;
      luma_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_WIDTH:     fw_q   <= cfg_data_i[FW_W-1:0];
        CFG_FRAME_HEIGHT:    fh_q   <= cfg_data_i[FH_W-1:0];
        CFG_COEF_CENTER:     cc_q   <= cfg_data_i[COEF_W-1:0];
        CFG_COEF_HORIZONTAL: ch_q   <= cfg_data_i[COEF_W-1:0];
        CFG_COEF_VERTICAL:   cv_q   <= cfg_data_i[COEF_W-1:0];
        CFG_SHARPEN_ENABLE:  en_q   <= cfg_data_i[0];
        CFG_LUMA_ONLY:       luma_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective geometry: zero reads as one, width saturates at MAX_WIDTH.
  logic [WW-1:0]   eff_w;
  logic [FH_W-1:0] eff_h;

  always_comb begin
    if (fw_q == '0) begin
      eff_w = WW'(1);
    end else if (EW'(fw_q) > EW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(fw_q);
    end
    eff_h = (fh_q == '0) ? FH_W'(1) : fh_q;
  end

  // ---------------------------------------------------------------------
  // Accept stage: raster counters, line buffer addressing
  // ---------------------------------------------------------------------
  logic [CW-1:0]   col_q, drn_q;
  logic [FH_W-1:0] row_q;
  logic [CNT_W-1:0] cnt_q;

  logic          draining, acc, acc_pix, acc_drn, res_acc;
  logic [WW-1:0] col_nx, drn_nx;
  logic          col_wrap, drn_last, border;
  logic [CW-1:0] rd_addr, rt_addr;
  logic [LW-1:0] pix_in;

  assign pix_i.ready = (cnt_q < CNT_W'(FIFO_DEPTH));

  always_comb begin
    draining = (row_q >= eff_h);
    acc      = pix_i.valid & pix_i.ready;
    acc_pix  = acc & ~draining & ~pix_i.data.flush;
    acc_drn  = acc & draining & pix_i.data.flush;
    col_nx   = WW'(col_q) + WW'(1);
    drn_nx   = WW'(drn_q) + WW'(1);
    col_wrap = (col_nx >= eff_w);
    drn_last = (drn_nx >= eff_w);
    // Row 0 output, first column, last column, or filter off: copy.
    border   = (row_q == FH_W'(1)) || (col_q == '0) || col_wrap || !en_q;
    res_acc  = (acc_pix & (row_q != '0)) | acc_drn;
    rd_addr  = draining ? drn_q : col_q;
    rt_addr  = (col_nx >= WW'(MAX_WIDTH)) ? '0 : col_nx[CW-1:0];
    pix_in   = {pix_i.data.chan_c[SB-1:0], pix_i.data.chan_b[SB-1:0],
                pix_i.data.chan_a[SB-1:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      drn_q <= '0;
      row_q <= '0;
    end else if (acc_pix) begin
      if (col_wrap) begin
        col_q <= '0;
        row_q <= row_q + FH_W'(1);
        drn_q <= '0;
      end else begin
        col_q <= col_nx[CW-1:0];
      end
    end else if (acc_drn) begin
      if (drn_last) begin
        col_q <= '0;
        row_q <= '0;
        drn_q <= '0;
      end else begin
        drn_q <= drn_nx[CW-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Line buffers. prev_mem holds the last row (two read ports: center and
  // right neighbor), prev2_mem the row before it, written from the read-stage
  // registers with the center value read out of prev_mem.
  // ---------------------------------------------------------------------
  logic [LW-1:0] prev_mem  [MAX_WIDTH];
  logic [LW-1:0] prev2_mem [MAX_WIDTH];
  logic [LW-1:0] rd_mid_q, rd_rt_q, rd_up_q;

  logic          b_vld_q, b_pix_q;
  logic [CW-1:0] b_x_q;
  logic [LW-1:0] b_dn_q;
  logic          b_f0_q, b_f12_q, b_eof_q, b_hz_q;
  logic [LW-1:0] lmid_q;

  always_ff @(posedge clk_i) begin
    rd_mid_q <= prev_mem[rd_addr];
    rd_rt_q  <= prev_mem[rt_addr];
    if (acc_pix) begin
      prev_mem[col_q] <= pix_in;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_up_q <= prev2_mem[col_q];
    if (b_pix_q) begin
      prev2_mem[b_x_q] <= rd_mid_q;
    end
  end

  // ---------------------------------------------------------------------
  // Read stage
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
      b_pix_q <= 1'b0;
    end else begin
      b_vld_q <= res_acc;
      b_pix_q <= acc_pix;
    end
  end

  always_ff @(posedge clk_i) begin
    b_x_q   <= col_q;
    b_dn_q  <= pix_in;
    b_f0_q  <= acc_pix & ~border;
    b_f12_q <= acc_pix & ~border & ~luma_q;
    b_eof_q <= acc_drn & drn_last;
    // Upper row entry written back in this very clock: take it from lmid_q.
    b_hz_q  <= b_pix_q && (b_x_q == col_q);
    if (b_pix_q) begin
      lmid_q <= rd_mid_q;
    end
  end

  // lmid_q is the center of the previous pixel, i.e. the left neighbor.
  logic [LW-1:0] b_up;
  coef_t         coef;

  assign b_up = b_hz_q ? lmid_q : rd_up_q;
  assign coef = '{center: cc_q, horizontal: ch_q, vertical: cv_q};

  logic [SB-1:0] res [3];

  for (genvar k = 0; k < 3; k++) begin : g_chan
    cksf_chan #(
      .SB (SB)
    ) u_chan (
      .clk_i  (clk_i),
      .filt_i ((k == 0) ? b_f0_q : b_f12_q),
      .coef_i (coef),
      .mid_i  (rd_mid_q[k*SB +: SB]),
      .up_i   (b_up[k*SB +: SB]),
      .dn_i   (b_dn_q[k*SB +: SB]),
      .lf_i   (lmid_q[k*SB +: SB]),
      .rt_i   (rd_rt_q[k*SB +: SB]),
      .res_o  (res[k])
    );
  end

  // ---------------------------------------------------------------------
  // Product stage control and output FIFO
  // ---------------------------------------------------------------------
  logic c_vld_q, c_eof_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_eof_q <= b_eof_q;
  end

  pix_out_t         fifo_mem [FIFO_DEPTH];
  logic [FPW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] fifo_cnt_q;
  logic             push, pop;
  pix_out_t         push_item;

  always_comb begin
    push      = c_vld_q;
    pop       = pix_o.valid & pix_o.ready;
    push_item = '{out_a:        SAMPLE_W'(res[0]),
                  out_b:        SAMPLE_W'(res[1]),
                  out_c:        SAMPLE_W'(res[2]),
                  end_of_frame: c_eof_q};
  end

  assign pix_o.valid = (fifo_cnt_q != '0);
  assign pix_o.data  = fifo_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_mem[wr_ptr_q] <= push_item;
    end
  end

  // cnt_q counts results from accept until they leave the FIFO.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
      cnt_q      <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + FPW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FPW'(1);
      end
      fifo_cnt_q <= fifo_cnt_q + CNT_W'(push) - CNT_W'(pop);
      cnt_q      <= cnt_q + CNT_W'(res_acc) - CNT_W'(pop);
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_fifo_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (fifo_cnt_q != CNT_W'(FIFO_DEPTH)))
    else $error("output FIFO overflow");

  a_credit_covers_fifo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q >= fifo_cnt_q)
    else $error("in-flight count below FIFO fill");

  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_acc |=> ##1 c_vld_q)
    else $error("result item lost in pipeline");

endmodule
